// ----- sv/nkro_pkg.sv -----
// shared constants and types for the nkro bitmap to boot report converter
// no dependencies; compile first
`timescale 1ns / 1ps

package nkro_pkg;

	localparam int MAX_PACKET_BYTES = 16;  // default packet size limit
	localparam int BOOT_LEN         = 8;   // bytes in a boot keyboard report
	localparam int SLOT_COUNT       = 6;   // key slots in a boot report
	localparam int KEY_BASE         = 4;   // keycode of bit 0 in the first bitmap byte
	localparam int FIRST_KEY_BYTE   = 2;   // packet byte where the key bitmap starts
	localparam int SLOT_W           = $clog2(SLOT_COUNT + 1);
	localparam int RANK_W           = $clog2(SLOT_COUNT + 8 + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] reserved_byte;
		logic [7:0] key_0;
		logic [7:0] key_1;
		logic [7:0] key_2;
		logic [7:0] key_3;
		logic [7:0] key_4;
		logic [7:0] key_5;
	} report_t;

endpackage

// ----- sv/nkro_pkt_if.sv -----
// packet byte channel: valid/ready handshake with one packet byte per beat
// depends on nothing
`timescale 1ns / 1ps

interface nkro_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/nkro_rpt_if.sv -----
// boot report channel: valid/ready handshake with one 8-byte report per beat
// depends on nothing
`timescale 1ns / 1ps

interface nkro_rpt_if;
	logic       valid;
	logic       ready;
	logic [7:0] modifier_bits;
	logic [7:0] reserved_byte;
	logic [7:0] key_0;
	logic [7:0] key_1;
	logic [7:0] key_2;
	logic [7:0] key_3;
	logic [7:0] key_4;
	logic [7:0] key_5;

	modport source (output valid, output modifier_bits, output reserved_byte,
		output key_0, output key_1, output key_2, output key_3, output key_4,
		output key_5, input ready);
	modport sink   (input valid, input modifier_bits, input reserved_byte,
		input key_0, input key_1, input key_2, input key_3, input key_4,
		input key_5, output ready);
endinterface

// ----- sv/nkro_in_stage.sv -----
// input register stage: captures one packet byte beat and holds it for the packer
// depends on nkro_pkg and nkro_pkt_if
`timescale 1ns / 1ps

module nkro_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	nkro_pkt_if.sink            pkt,
	output logic                beat_valid,
	output nkro_pkg::byte_beat_t beat,
	input  logic                beat_take
);

	logic                 valid_s1;
	nkro_pkg::byte_beat_t beat_s1;

	// refill in the same cycle the held beat drains
	assign pkt.ready  = !valid_s1 || beat_take;
	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.valid && pkt.ready) begin
			valid_s1 <= 1'b1;
		end else if (beat_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			beat_s1.data_byte <= pkt.data_byte;
			beat_s1.last_byte <= pkt.last_byte;
		end
	end

endmodule

// ----- sv/nkro_pack.sv -----
// packet accumulator: head bytes, byte count, key slot compaction and report register
// depends on nkro_pkg and nkro_rpt_if
`timescale 1ns / 1ps

module nkro_pack #(
	parameter int MaxPacketBytes = nkro_pkg::MAX_PACKET_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat_valid,
	input  nkro_pkg::byte_beat_t beat,
	output logic                 beat_take,
	nkro_rpt_if.source           rpt
);

	localparam int CntW = $clog2(MaxPacketBytes + 1);

	logic [CntW-1:0]             cnt_q, cnt_n;
	logic [7:0]                  head_q [nkro_pkg::BOOT_LEN];
	logic [7:0]                  head_n [nkro_pkg::BOOT_LEN];
	logic [nkro_pkg::SLOT_W-1:0] filled_q, filled_n;
	logic [7:0]                  slot_q [nkro_pkg::SLOT_COUNT];
	logic [7:0]                  slot_n [nkro_pkg::SLOT_COUNT];
	logic                        rpt_valid_q;
	nkro_pkg::report_t           rpt_q, rpt_n;

	logic                        active;
	logic                        key_en;
	logic [7:0]                  base_code;
	logic [7:0]                  code [8];
	logic [nkro_pkg::RANK_W-1:0] rank [8];
	logic [nkro_pkg::RANK_W-1:0] total;

	assign beat_take = beat_valid && (!beat.last_byte || !rpt_valid_q || rpt.ready);

	always_comb begin
		active    = cnt_q < CntW'(MaxPacketBytes);
		key_en    = active && (cnt_q >= CntW'(nkro_pkg::FIRST_KEY_BYTE));
		cnt_n     = active ? cnt_q + CntW'(1) : cnt_q;
		base_code = (8'(cnt_q) - 8'(nkro_pkg::FIRST_KEY_BYTE)) << 3;

		head_n = head_q;
		if (active && cnt_q < CntW'(nkro_pkg::BOOT_LEN)) begin
			head_n[cnt_q[2:0]] = beat.data_byte;
		end

		// slot index each set bit lands on, in ascending bit order
		total = nkro_pkg::RANK_W'(filled_q);
		for (int b = 0; b < 8; b++) begin
			code[b] = base_code + 8'(b) + 8'(nkro_pkg::KEY_BASE);
			rank[b] = total;
			if (beat.data_byte[b]) begin
				total = total + nkro_pkg::RANK_W'(1);
			end
		end

		slot_n   = slot_q;
		filled_n = filled_q;
		if (key_en) begin
			for (int j = 0; j < nkro_pkg::SLOT_COUNT; j++) begin
				for (int b = 0; b < 8; b++) begin
					if (beat.data_byte[b] && rank[b] == nkro_pkg::RANK_W'(j)) begin
						slot_n[j] = code[b];
					end
				end
			end
			if (total > nkro_pkg::RANK_W'(nkro_pkg::SLOT_COUNT)) begin
				filled_n = nkro_pkg::SLOT_W'(nkro_pkg::SLOT_COUNT);
			end else begin
				filled_n = total[nkro_pkg::SLOT_W-1:0];
			end
		end

		rpt_n = '0;
		if (cnt_n == CntW'(nkro_pkg::BOOT_LEN)) begin
			rpt_n = {head_n[0], head_n[1], head_n[2], head_n[3],
				head_n[4], head_n[5], head_n[6], head_n[7]};
		end else if (cnt_n > CntW'(nkro_pkg::BOOT_LEN)) begin
			rpt_n = {head_n[0], 8'h00, slot_n[0], slot_n[1],
				slot_n[2], slot_n[3], slot_n[4], slot_n[5]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			filled_q <= '0;
			for (int i = 0; i < nkro_pkg::BOOT_LEN; i++) begin
				head_q[i] <= '0;
			end
			for (int j = 0; j < nkro_pkg::SLOT_COUNT; j++) begin
				slot_q[j] <= '0;
			end
		end else if (beat_take) begin
			if (beat.last_byte) begin
				// last byte taken and report registered, start the next packet clean
				cnt_q    <= '0;
				filled_q <= '0;
				for (int i = 0; i < nkro_pkg::BOOT_LEN; i++) begin
					head_q[i] <= '0;
				end
				for (int j = 0; j < nkro_pkg::SLOT_COUNT; j++) begin
					slot_q[j] <= '0;
				end
			end else begin
				cnt_q    <= cnt_n;
				filled_q <= filled_n;
				head_q   <= head_n;
				slot_q   <= slot_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (beat_take && beat.last_byte) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_take && beat.last_byte) begin
			rpt_q <= rpt_n;
		end
	end

	assign rpt.valid         = rpt_valid_q;
	assign rpt.modifier_bits = rpt_q.modifier_bits;
	assign rpt.reserved_byte = rpt_q.reserved_byte;
	assign rpt.key_0         = rpt_q.key_0;
	assign rpt.key_1         = rpt_q.key_1;
	assign rpt.key_2         = rpt_q.key_2;
	assign rpt.key_3         = rpt_q.key_3;
	assign rpt.key_4         = rpt_q.key_4;
	assign rpt.key_5         = rpt_q.key_5;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxPacketBytes))
		else $error("byte count past packet limit");

	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= nkro_pkg::SLOT_W'(nkro_pkg::SLOT_COUNT))
		else $error("more key slots filled than exist");

	a_keys_after_head: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q != '0 |-> cnt_q > CntW'(nkro_pkg::FIRST_KEY_BYTE))
		else $error("keys recorded before the bitmap bytes");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		beat_take && beat.last_byte |=> cnt_q == '0 && filled_q == '0 && rpt_valid_q)
		else $error("packet end did not clear state and raise a report");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid_q && !rpt.ready |-> !(beat_take && beat.last_byte))
		else $error("report overwritten before it was taken");

endmodule

// ----- sv/nkro_bitmap_to_boot_report.sv -----
// Converts an NKRO keyboard HID packet, received one byte per beat on pkt with
// last_byte marking the end, into one 8-byte boot keyboard report on rpt.
// Bytes are taken at one per clock; a packet's report is registered after its last
// byte leaves the input stage, held in a report register so the next packet streams
// in while it waits. The only stall is a last byte meeting a report not yet taken.
// Top level; depends on nkro_pkg, nkro_pkt_if, nkro_rpt_if, nkro_in_stage, nkro_pack.
`timescale 1ns / 1ps

module nkro_bitmap_to_boot_report #(
	parameter int MaxPacketBytes = nkro_pkg::MAX_PACKET_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	nkro_pkt_if.sink   pkt,
	nkro_rpt_if.source rpt
);

	logic                 beat_valid;
	logic                 beat_take;
	nkro_pkg::byte_beat_t beat;

	nkro_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.beat_valid (beat_valid),
		.beat       (beat),
		.beat_take  (beat_take)
	);

	nkro_pack #(
		.MaxPacketBytes (MaxPacketBytes)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat       (beat),
		.beat_take  (beat_take),
		.rpt        (rpt)
	);

endmodule
